/* hw/rtl/pspwm_pkg.sv */
// ----------------------------------------------------------------------------
// pspwm_pkg
// Shared constants for the phase-shifted multichannel PWM unit: channel
// count, phase step and wrap values, per-channel start phases and opcodes.
// ----------------------------------------------------------------------------
package pspwm_pkg;

  localparam int CHANNELS = 7;

  localparam int PIN_W   = 7;
  localparam int SLOT_W  = 3;
  localparam int LEVEL_W = 8;

  localparam logic [SLOT_W-1:0]  SLOT_LIMIT = SLOT_W'(CHANNELS);
  localparam logic [LEVEL_W-1:0] PHASE_WRAP = 8'd148;
  localparam logic [LEVEL_W-1:0] PHASE_STEP = 8'd107;

  localparam logic [LEVEL_W-1:0] START_PHASE [0:6] = '{
    8'd0, 8'd197, 8'd138, 8'd79, 8'd20, 8'd217, 8'd158
  };

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic [SLOT_W-1:0]  slot_t;
  typedef logic [PIN_W-1:0]   pins_t;

  function automatic level_t advance_phase(input level_t c);
    level_t r;
    if (c >= PHASE_WRAP) begin
      r = c - PHASE_WRAP;
    end else begin
      r = c + PHASE_STEP;
    end
    return r;
  endfunction

endpackage

/* hw/rtl/phase_shifted_multichannel_pwm_unit.sv */
// ----------------------------------------------------------------------------
// phase_shifted_multichannel_pwm_unit
// Seven-channel phase-shifted PWM with a slot pointer and per-channel duty.
// ----------------------------------------------------------------------------
// Each accepted word is either a timer tick or a duty write and produces one
// result word with the pin levels and the slot pointer after that word. A
// word is taken in every cycle in which in_stall is low, and its result is
// captured in the output register in the cycle after it is taken; the
// compare and phase advance per tick lie between the channel state
// registers and that output register. in_stall rises only while a result
// sits in the output register and out_stall is high. Reset loads the
// start phases, clears duties and the slot pointer, and sets pins_r high.
module phase_shifted_multichannel_pwm_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_opcode,
  input  logic [2:0]                       in_led_index,
  input  logic [pspwm_pkg::LEVEL_W-1:0]    in_duty_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [pspwm_pkg::PIN_W-1:0]      out_led_pins,
  output logic [pspwm_pkg::SLOT_W-1:0]     out_frame_slot
);
  import pspwm_pkg::*;

  level_t phase_r [CHANNELS];
  level_t phase_nxt [CHANNELS];
  level_t duty_r [CHANNELS];
  level_t duty_nxt [CHANNELS];
  pins_t  pins_r, pins_nxt;
  slot_t  slot_r, slot_nxt;

  logic   out_valid_r;
  pins_t  out_pins_r;
  slot_t  out_slot_r;

  logic   accept;
  logic   is_tick;
  logic   is_write;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;
  assign is_tick  = accept & (in_opcode == OP_TICK);
  assign is_write = accept & (in_opcode == OP_WRITE);

  always_comb begin
    pins_nxt = pins_r;
    for (int i = 0; i < CHANNELS; i++) begin
      phase_nxt[i] = phase_r[i];
      duty_nxt[i]  = duty_r[i];
      if (is_tick && slot_r == SLOT_W'(i)) begin
        pins_nxt[i]  = (phase_r[i] >= duty_r[i]);
        phase_nxt[i] = advance_phase(phase_r[i]);
      end
      if (is_write && in_led_index == SLOT_W'(i)) begin
        duty_nxt[i] = in_duty_value;
      end
    end
    slot_nxt = slot_r;
    if (is_tick) begin
      slot_nxt = (slot_r < SLOT_LIMIT) ? slot_r + 1'b1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        phase_r[i] <= START_PHASE[i];
        duty_r[i]  <= '0;
      end
      pins_r      <= '1;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      duty_r  <= duty_nxt;
      pins_r  <= pins_nxt;
      slot_r  <= slot_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_pins_r <= pins_nxt;
      out_slot_r <= slot_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_led_pins   = out_pins_r;
  assign out_frame_slot = out_slot_r;

  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result word");

  a_write_keeps_slot: assert property (@(posedge clk) disable iff (!rst_n)
    is_write |=> slot_r == $past(slot_r))
    else $error("duty write moved the slot pointer");

  a_idle_slot_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (is_tick && slot_r >= SLOT_LIMIT) |=> (slot_r == '0 && pins_r == $past(pins_r)))
    else $error("idle tick did not wrap the slot pointer cleanly");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_slot_r == slot_r && out_pins_r == pins_r))
    else $error("result word differs from updated state");

endmodule
